// File: src/kpmd_pkg.sv
// Shared constants for the Kepler point-mass derivative pipeline.
`timescale 1ns / 1ps
`default_nettype none
package kpmd_pkg;

    // GM register: unsigned fixed point, 31 bits
    localparam int GM_W = 31;
    // Reset value of GM: 1.0 in Q15.16
    localparam logic [GM_W-1:0] GM_RESET = GM_W'(65536);

endpackage
`default_nettype wire

// File: src/kepler_point_mass_derivative.sv
// Top level: two-body Kepler state derivative, fully pipelined.
// Throughput: one item per cycle while the output is not stalled; the square root
// and the three dividers are unrolled pipelines, one result bit per stage.
// Backpressure stalls every stage together; s_tready follows the output register.
// Reset (synchronous, aresetn low) empties the pipeline and loads GM = 1.0.
`timescale 1ns / 1ps
`default_nettype none
module kepler_point_mass_derivative #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // GM write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [kpmd_pkg::GM_W-1:0]              cfg_data,
    // input items
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (lowest first), zero pad
    input  wire logic [((6*WORD_BITS+7)/8)*8-1:0]       s_tdata,
    // result items
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // tdata: dpos_x, dpos_y, dpos_z, accel_x, accel_y, accel_z (lowest first)
    output logic [((6*WORD_BITS+7)/8)*8-1:0]            m_tdata,
    // tuser: singular
    output logic [0:0]                                  m_tuser
);
    import kpmd_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int TD_W   = ((6 * W + 7) / 8) * 8;
    localparam int NUM_W  = GM_W + W + 2 * F;
    localparam int REM_W  = (NUM_W > 4 * W) ? NUM_W : 4 * W;
    localparam int SQ_TAG = 6 * W + 4;
    localparam int L0_TAG = 3 * W + 2;

    // ---------------- configuration ----------------
    logic [GM_W-1:0] gm_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm_reg <= GM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            gm_reg <= cfg_data;
        end
    end

    // Whole pipeline advances when the output register is free or drained.
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: magnitudes ----------------
    logic [W-1:0]   pos_w    [3];
    logic [W-1:0]   mag_next [3];
    logic [2:0]     neg_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_w[i]    = s_tdata[i*W +: W];
            neg_next[i] = pos_w[i][W-1];
            mag_next[i] = neg_next[i] ? (~pos_w[i] + W'(1)) : pos_w[i];
        end
    end

    logic           s1_vld_reg;
    logic [W-1:0]   s1_mag_reg [3];
    logic [2:0]     s1_neg_reg;
    logic [3*W-1:0] s1_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mag_reg <= mag_next;
            s1_neg_reg <= neg_next;
            s1_vel_reg <= s_tdata[3*W +: 3*W];
        end
    end

    // ---------------- stage 2: squares ----------------
    logic           s2_vld_reg;
    logic [2*W-1:0] s2_sq_reg  [3];
    logic [W-1:0]   s2_mag_reg [3];
    logic [2:0]     s2_neg_reg;
    logic [3*W-1:0] s2_vel_reg;
    logic           s2_sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s2_sq_reg[i] <= (2*W)'(s1_mag_reg[i]) * (2*W)'(s1_mag_reg[i]);
            end
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_vel_reg  <= s1_vel_reg;
            // all position words zero: distance is zero
            s2_sing_reg <= (s1_mag_reg[0] == '0) && (s1_mag_reg[1] == '0)
                           && (s1_mag_reg[2] == '0);
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    // Sum is at most 3 * 2^(2W-2), so 2W bits hold it.
    logic              s3_vld_reg;
    logic [2*W-1:0]    s3_sum_reg;
    logic [SQ_TAG-1:0] s3_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_sum_reg <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_tag_reg <= {s2_vel_reg, s2_mag_reg[2], s2_mag_reg[1], s2_mag_reg[0],
                           s2_neg_reg, s2_sing_reg};
        end
    end

    // ---------------- distance: square root pipeline ----------------
    logic              sq_vld;
    logic [W-1:0]      sq_root;
    logic [SQ_TAG-1:0] sq_tag;

    kpmd_isqrt #(
        .W     (W),
        .TAG_W (SQ_TAG)
    ) u_isqrt (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (adv),
        .in_valid  (s3_vld_reg),
        .in_sq     (s3_sum_reg),
        .in_tag    (s3_tag_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    logic [3*W-1:0] sq_vel;
    logic [W-1:0]   sq_mag [3];
    logic [2:0]     sq_neg;
    logic           sq_sing;

    assign sq_sing   = sq_tag[0];
    assign sq_neg    = sq_tag[3:1];
    assign sq_mag[0] = sq_tag[4 +: W];
    assign sq_mag[1] = sq_tag[4 + W +: W];
    assign sq_mag[2] = sq_tag[4 + 2*W +: W];
    assign sq_vel    = sq_tag[4 + 3*W +: 3*W];

    // ---------------- cube and numerators ----------------
    // c1: R^2 and GM * |p_i|
    logic                c1_vld_reg;
    logic [W-1:0]        c1_r_reg;
    logic [2*W-1:0]      c1_r2_reg;
    logic [GM_W+W-1:0]   c1_num_reg [3];
    logic [3*W-1:0]      c1_vel_reg;
    logic [2:0]          c1_neg_reg;
    logic                c1_sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg <= 1'b0;
        end else if (adv) begin
            c1_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_r_reg  <= sq_root;
            c1_r2_reg <= (2*W)'(sq_root) * (2*W)'(sq_root);
            for (int i = 0; i < 3; i++) begin
                c1_num_reg[i] <= (GM_W+W)'(gm_reg) * (GM_W+W)'(sq_mag[i]);
            end
            c1_vel_reg  <= sq_vel;
            c1_neg_reg  <= sq_neg;
            c1_sing_reg <= sq_sing;
        end
    end

    // c2: R^2 * R as two W x W partial products
    logic                c2_vld_reg;
    logic [2*W-1:0]      c2_plo_reg;
    logic [2*W-1:0]      c2_phi_reg;
    logic [GM_W+W-1:0]   c2_num_reg [3];
    logic [3*W-1:0]      c2_vel_reg;
    logic [2:0]          c2_neg_reg;
    logic                c2_sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_vld_reg <= 1'b0;
        end else if (adv) begin
            c2_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2_plo_reg  <= (2*W)'(c1_r2_reg[W-1:0]) * (2*W)'(c1_r_reg);
            c2_phi_reg  <= (2*W)'(c1_r2_reg[2*W-1:W]) * (2*W)'(c1_r_reg);
            c2_num_reg  <= c1_num_reg;
            c2_vel_reg  <= c1_vel_reg;
            c2_neg_reg  <= c1_neg_reg;
            c2_sing_reg <= c1_sing_reg;
        end
    end

    // c3: combine partial products into R^3 (fits 3W bits)
    logic                c3_vld_reg;
    logic [3*W-1:0]      c3_den_reg;
    logic [GM_W+W-1:0]   c3_num_reg [3];
    logic [3*W-1:0]      c3_vel_reg;
    logic [2:0]          c3_neg_reg;
    logic                c3_sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_vld_reg <= 1'b0;
        end else if (adv) begin
            c3_vld_reg <= c2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c3_den_reg  <= (3*W)'(c2_plo_reg) + ((3*W)'(c2_phi_reg) << W);
            c3_num_reg  <= c2_num_reg;
            c3_vel_reg  <= c2_vel_reg;
            c3_neg_reg  <= c2_neg_reg;
            c3_sing_reg <= c2_sing_reg;
        end
    end

    // ---------------- division lanes ----------------
    // Q_i = floor(GM * |p_i| * 2^(2F) / R^3); lane 0 carries the side data.
    logic [REM_W-1:0] dv_num  [3];
    logic             dv_vld  [3];
    logic [W-1:0]     dv_quot [3];
    logic             dv_sat  [3];
    logic [L0_TAG-1:0] l0_tag;
    logic [0:0]        l1_tag;
    logic [0:0]        l2_tag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_num[i] = REM_W'({c3_num_reg[i], {(2*F){1'b0}}});
        end
    end

    kpmd_div_lane #(
        .W     (W),
        .REM_W (REM_W),
        .DEN_W (3*W),
        .TAG_W (L0_TAG)
    ) u_div_x (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (adv),
        .in_valid  (c3_vld_reg),
        .in_num    (dv_num[0]),
        .in_den    (c3_den_reg),
        .in_tag    ({c3_vel_reg, c3_sing_reg, c3_neg_reg[0]}),
        .out_valid (dv_vld[0]),
        .out_quot  (dv_quot[0]),
        .out_sat   (dv_sat[0]),
        .out_tag   (l0_tag)
    );

    kpmd_div_lane #(
        .W     (W),
        .REM_W (REM_W),
        .DEN_W (3*W),
        .TAG_W (1)
    ) u_div_y (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (adv),
        .in_valid  (c3_vld_reg),
        .in_num    (dv_num[1]),
        .in_den    (c3_den_reg),
        .in_tag    (c3_neg_reg[1]),
        .out_valid (dv_vld[1]),
        .out_quot  (dv_quot[1]),
        .out_sat   (dv_sat[1]),
        .out_tag   (l1_tag)
    );

    kpmd_div_lane #(
        .W     (W),
        .REM_W (REM_W),
        .DEN_W (3*W),
        .TAG_W (1)
    ) u_div_z (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (adv),
        .in_valid  (c3_vld_reg),
        .in_num    (dv_num[2]),
        .in_den    (c3_den_reg),
        .in_tag    (c3_neg_reg[2]),
        .out_valid (dv_vld[2]),
        .out_quot  (dv_quot[2]),
        .out_sat   (dv_sat[2]),
        .out_tag   (l2_tag)
    );

    // ---------------- output: sign, saturation, register ----------------
    logic [2:0]     dv_neg;
    logic           dv_sing;
    logic [3*W-1:0] dv_vel;
    logic [W-1:0]   acc_next [3];
    logic [W-1:0]   max_pos;
    logic [W-1:0]   min_neg;

    assign dv_neg  = {l2_tag[0], l1_tag[0], l0_tag[0]};
    assign dv_sing = l0_tag[1];
    assign dv_vel  = l0_tag[2 +: 3*W];
    assign min_neg = W'(1) << (W - 1);
    assign max_pos = ~min_neg;

    // Acceleration points against the position: positive p gives negative a.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_sing) begin
                acc_next[i] = '0;
            end else if (!dv_neg[i]) begin
                acc_next[i] = (dv_sat[i] || dv_quot[i][W-1]) ? min_neg
                                                             : (~dv_quot[i] + W'(1));
            end else begin
                acc_next[i] = (dv_sat[i] || dv_quot[i][W-1]) ? max_pos : dv_quot[i];
            end
        end
    end

    logic [TD_W-1:0] m_tdata_reg;
    logic            m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_vld[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= TD_W'({acc_next[2], acc_next[1], acc_next[0], dv_vel});
            m_tuser_reg <= dv_sing;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- assertions ----------------
    // A singular item never carries a nonzero acceleration.
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[3*W +: 3*W] == '0))
        else $error("singular item with nonzero acceleration");

    // The three divider lanes stay in lockstep.
    a_lanes_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld[0] == dv_vld[1]) && (dv_vld[0] == dv_vld[2]))
        else $error("divider lanes out of step");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

// File: src/kpmd_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side tag.
`timescale 1ns / 1ps
`default_nettype none
module kpmd_isqrt #(
    parameter int W     = 32,
    parameter int TAG_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [2*W-1:0]   in_sq,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic [W-1:0]          out_root,
    output logic [TAG_W-1:0]      out_tag
);
    import kpmd_pkg::*;

    localparam int RW = 2 * W + 2;

    logic [RW-1:0]    rem_reg  [W-1];
    logic [W-1:0]     root_reg [W];
    logic [TAG_W-1:0] tag_reg  [W];
    logic             vld_reg  [W];

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stg
            localparam int B = W - 1 - k;
            logic [RW-1:0]    rem_prev;
            logic [RW-1:0]    trial;
            logic [W-1:0]     root_prev;
            logic [TAG_W-1:0] tag_prev;
            logic             vld_prev;
            logic             take;
            logic [RW-1:0]    rem_next;
            logic [W-1:0]     root_next;

            if (k == 0) begin : g_first
                assign rem_prev  = RW'(in_sq);
                assign root_prev = '0;
                assign tag_prev  = in_tag;
                assign vld_prev  = in_valid;
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign tag_prev  = tag_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
            end

            // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
            assign trial     = (RW'(root_prev) << (B + 1)) + (RW'(1) << (2 * B));
            assign take      = (rem_prev >= trial);
            assign rem_next  = take ? (rem_prev - trial) : rem_prev;
            assign root_next = take ? (root_prev | (W'(1) << B)) : root_prev;

            always_ff @(posedge clk) begin
                if (!rst_n) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk) begin
                if (en) begin
                    root_reg[k] <= root_next;
                    tag_reg[k]  <= tag_prev;
                end
            end

            if (k < W - 1) begin : g_rem
                always_ff @(posedge clk) begin
                    if (en) begin
                        rem_reg[k] <= rem_next;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W-1];
    assign out_root  = root_reg[W-1];
    assign out_tag   = tag_reg[W-1];

endmodule
`default_nettype wire

// File: src/kpmd_div_lane.sv
// Pipelined restoring divider lane with overflow detect and a side tag.
`timescale 1ns / 1ps
`default_nettype none
module kpmd_div_lane #(
    parameter int W     = 32,
    parameter int REM_W = 128,
    parameter int DEN_W = 96,
    parameter int TAG_W = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [REM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic [W-1:0]          out_quot,
    output logic                  out_sat,
    output logic [TAG_W-1:0]      out_tag
);
    import kpmd_pkg::*;

    // entry stage: quotient overflow check
    logic             ent_vld_reg;
    logic [REM_W-1:0] ent_rem_reg;
    logic [DEN_W-1:0] ent_den_reg;
    logic             ent_sat_reg;
    logic [TAG_W-1:0] ent_tag_reg;
    logic             ent_sat_next;

    assign ent_sat_next = (in_num >= (REM_W'(in_den) << W));

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            ent_vld_reg <= 1'b0;
        end else if (en) begin
            ent_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            ent_rem_reg <= in_num;
            ent_den_reg <= in_den;
            ent_sat_reg <= ent_sat_next;
            ent_tag_reg <= in_tag;
        end
    end

    logic [REM_W-1:0] rem_reg  [W-1];
    logic [DEN_W-1:0] den_reg  [W-1];
    logic [W-1:0]     quot_reg [W];
    logic             sat_reg  [W];
    logic [TAG_W-1:0] tag_reg  [W];
    logic             vld_reg  [W];

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stg
            localparam int B = W - 1 - k;
            logic [REM_W-1:0] rem_prev;
            logic [DEN_W-1:0] den_prev;
            logic [W-1:0]     quot_prev;
            logic             sat_prev;
            logic [TAG_W-1:0] tag_prev;
            logic             vld_prev;
            logic [REM_W-1:0] shifted;
            logic             take;
            logic [REM_W-1:0] rem_next;
            logic [W-1:0]     quot_next;

            if (k == 0) begin : g_first
                assign rem_prev  = ent_rem_reg;
                assign den_prev  = ent_den_reg;
                assign quot_prev = '0;
                assign sat_prev  = ent_sat_reg;
                assign tag_prev  = ent_tag_reg;
                assign vld_prev  = ent_vld_reg;
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign den_prev  = den_reg[k-1];
                assign quot_prev = quot_reg[k-1];
                assign sat_prev  = sat_reg[k-1];
                assign tag_prev  = tag_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
            end

            assign shifted   = REM_W'(den_prev) << B;
            assign take      = (rem_prev >= shifted);
            assign rem_next  = take ? (rem_prev - shifted) : rem_prev;
            assign quot_next = take ? (quot_prev | (W'(1) << B)) : quot_prev;

            always_ff @(posedge clk) begin
                if (!rst_n) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk) begin
                if (en) begin
                    quot_reg[k] <= quot_next;
                    sat_reg[k]  <= sat_prev;
                    tag_reg[k]  <= tag_prev;
                end
            end

            if (k < W - 1) begin : g_carry
                always_ff @(posedge clk) begin
                    if (en) begin
                        rem_reg[k] <= rem_next;
                        den_reg[k] <= den_prev;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W-1];
    assign out_quot  = quot_reg[W-1];
    assign out_sat   = sat_reg[W-1];
    assign out_tag   = tag_reg[W-1];

endmodule
`default_nettype wire
